### hdl/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, held off while reset is asserted.
`define RPVG_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define RPVG_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/rpvg_pkg.sv
package rpvg_pkg;

    // Field widths.
    localparam int SIDES_W  = 7;
    localparam int VNUM_W   = 6;
    localparam int COORD_W  = 17;
    localparam int Q88_W    = 16;
    localparam int TEX_W    = 16;
    localparam int COLOR_W  = 8;
    localparam int PHASE_W  = 32;
    localparam int FRAC_W   = 30;

    // Internal arithmetic widths.
    localparam int CW       = 34;   // CORDIC x, y, z in Q2.30 with headroom
    localparam int TRIG_W   = 32;   // clamped sine and cosine
    localparam int PROD_W   = 49;   // radius times trig
    localparam int QUOT_W   = 33;   // 2^32 / n needs 33 bits when n is one
    localparam int DIV_STEPS = 33;

    // Configuration port.
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    typedef enum logic [1:0] {
        REG_RED   = 2'd0,
        REG_GREEN = 2'd1,
        REG_BLUE  = 2'd2,
        REG_ALPHA = 2'd3
    } reg_idx_t;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'hFF;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_CORDIC,
        ST_MAP,
        ST_MUL_X,
        ST_MUL_Y,
        ST_EMIT
    } state_t;

    // Fixed-point constants.
    localparam logic [30:0]          HALF_PI_Q30     = 31'd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30         = 34'sd1073741824;

    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // Clamp a CORDIC output to the unit range.
    function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [CW-1:0] v);
        logic signed [TRIG_W-1:0] r;
        if (v > ONE_Q30) begin
            r = TRIG_W'(ONE_Q30);
        end else if (v < -ONE_Q30) begin
            r = TRIG_W'(-ONE_Q30);
        end else begin
            r = $signed(v[TRIG_W-1:0]);
        end
        return r;
    endfunction

    // Round a radius product back to Q8.8, half up, keeping 17 bits.
    function automatic logic [COORD_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + 49'sd536870912;
        return s[46:30];
    endfunction

    // Map a trig value to a Q0.16 texture coordinate, saturated at the top.
    function automatic logic [TEX_W-1:0] tex_of(input logic signed [TRIG_W-1:0] t);
        logic signed [TRIG_W:0] s;
        logic [17:0]            q;
        s = {t[TRIG_W-1], t} + 33'sd1073758208;
        q = s[32:15];
        return (q > 18'd65535) ? 16'hFFFF : q[15:0];
    endfunction

endpackage

### hdl/regular_polygon_vertex_generator.sv
// Sequence: each request runs the reciprocal divider once, then per vertex the
// CORDIC iterations, the quadrant map, two multiplies and the output load,
// which waits until the output slot is free.
// Throughput: one request at a time; s_ready is high only between requests.
// Reset (aresetn low, synchronous): sequencer idle, no result pending, colours 255.
`include "assert_macros.svh"

module regular_polygon_vertex_generator #(
    parameter int MAX_SIDES    = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rpvg_pkg::PADDR_W-1:0]         paddr,
    input  logic [rpvg_pkg::PDATA_W-1:0]         pwdata,
    output logic [rpvg_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready,
    // Request channel.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rpvg_pkg::SIDES_W-1:0]         s_side_count,
    input  logic [rpvg_pkg::Q88_W-1:0]           s_radius_q,
    input  logic signed [rpvg_pkg::Q88_W-1:0]    s_height_q,
    // Vertex channel.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rpvg_pkg::VNUM_W-1:0]          m_vertex_number,
    output logic signed [rpvg_pkg::COORD_W-1:0]  m_x_coord,
    output logic signed [rpvg_pkg::COORD_W-1:0]  m_y_coord,
    output logic signed [rpvg_pkg::Q88_W-1:0]    m_z_coord,
    output logic [rpvg_pkg::TEX_W-1:0]           m_tex_u,
    output logic [rpvg_pkg::TEX_W-1:0]           m_tex_v,
    output logic [rpvg_pkg::COLOR_W-1:0]         m_out_red,
    output logic [rpvg_pkg::COLOR_W-1:0]         m_out_green,
    output logic [rpvg_pkg::COLOR_W-1:0]         m_out_blue,
    output logic [rpvg_pkg::COLOR_W-1:0]         m_out_alpha,
    output logic                                 m_last_vertex
);
    import rpvg_pkg::*;

    state_t state_reg, state_next;

    // Colour registers.
    logic [COLOR_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic               cfg_write;
    reg_idx_t           cfg_idx;

    // Request and per-vertex state.
    logic [SIDES_W-1:0]       n_sat;
    logic [SIDES_W-1:0]       n_reg;
    logic [Q88_W-1:0]         radius_reg;
    logic signed [Q88_W-1:0]  height_reg;
    logic [PHASE_W-1:0]       phase_reg;
    logic [SIDES_W-1:0]       racc_reg;
    logic [VNUM_W-1:0]        vcnt_reg;
    logic signed [TRIG_W-1:0] cs_reg, sn_reg;
    logic [COORD_W-1:0]       x_res_reg;

    // Sequencer controls.
    logic accept, div_start, cordic_start, mul_en, emit_load, slot_free, is_last;

    // Submodule links.
    logic [QUOT_W-1:0]    quot;
    logic [SIDES_W-1:0]   rem;
    logic                 div_done;
    logic                 cordic_done;
    logic signed [CW-1:0] cx, cy, z_init;
    logic [60:0]          zprod;
    logic signed [TRIG_W-1:0] mul_trig;
    logic signed [PROD_W-1:0] prod;

    // Phase step bookkeeping.
    logic [SIDES_W:0]     rsum;
    logic                 rwrap;

    // Output registers.
    logic                     m_valid_reg;
    logic [VNUM_W-1:0]        vnum_out_reg;
    logic [COORD_W-1:0]       x_out_reg, y_out_reg;
    logic signed [Q88_W-1:0]  z_out_reg;
    logic [TEX_W-1:0]         u_out_reg, v_out_reg;
    logic [COLOR_W-1:0]       r_out_reg, g_out_reg, b_out_reg, a_out_reg;
    logic                     last_out_reg;

    // Configuration writes and reads; the register index is the word address.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg   <= COLOR_RESET;
            green_reg <= COLOR_RESET;
            blue_reg  <= COLOR_RESET;
            alpha_reg <= COLOR_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_RED:   red_reg   <= pwdata[COLOR_W-1:0];
                REG_GREEN: green_reg <= pwdata[COLOR_W-1:0];
                REG_BLUE:  blue_reg  <= pwdata[COLOR_W-1:0];
                REG_ALPHA: alpha_reg <= pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RED:   prdata = {24'd0, red_reg};
            REG_GREEN: prdata = {24'd0, green_reg};
            REG_BLUE:  prdata = {24'd0, blue_reg};
            REG_ALPHA: prdata = {24'd0, alpha_reg};
            default:   prdata = '0;
        endcase
    end

    // Side count saturated to the largest supported polygon.
    assign n_sat = (s_side_count > SIDES_W'(MAX_SIDES)) ? SIDES_W'(MAX_SIDES) : s_side_count;

    assign slot_free = !m_valid_reg || m_ready;
    assign is_last   = (({1'b0, vcnt_reg} + SIDES_W'(1)) == n_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && (n_sat != '0)) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:   state_next = ST_CORDIC;
            ST_CORDIC: begin
                if (cordic_done) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:    state_next = ST_MUL_X;
            ST_MUL_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = is_last ? ST_IDLE : ST_PREP;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready      = 1'b0;
        div_start    = 1'b0;
        cordic_start = 1'b0;
        mul_en       = 1'b0;
        emit_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = s_valid && (n_sat != '0);
            end
            ST_PREP:  cordic_start = 1'b1;
            ST_MUL_X: mul_en = 1'b1;
            ST_MUL_Y: mul_en = 1'b1;
            ST_EMIT:  emit_load = slot_free;
            default: ;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Reciprocal of the side count as a fraction of a full turn.
    rpvg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .divisor   (n_sat),
        .quotient  (quot),
        .remainder (rem),
        .done      (div_done)
    );

    // Quarter-turn fraction scaled to radians in Q2.30; the angle reaches 31 bits.
    assign zprod  = 61'(phase_reg[FRAC_W-1:0]) * 61'(HALF_PI_Q30);
    assign z_init = $signed({3'b000, zprod[60:30]});

    rpvg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .z_init  (z_init),
        .x_out   (cx),
        .y_out   (cy),
        .done    (cordic_done)
    );

    // One multiplier serves both coordinates in consecutive cycles.
    assign mul_trig = (state_reg == ST_MUL_Y) ? sn_reg : cs_reg;

    rpvg_mul u_mul (
        .aclk   (aclk),
        .en     (mul_en),
        .radius (radius_reg),
        .trig   (mul_trig),
        .prod   (prod)
    );

    // Next phase: add the quotient and carry the remainder modulo n.
    assign rsum  = {1'b0, racc_reg} + {1'b0, rem};
    assign rwrap = (rsum >= {1'b0, n_reg});

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            n_reg      <= n_sat;
            radius_reg <= s_radius_q;
            height_reg <= s_height_q;
            phase_reg  <= '0;
            racc_reg   <= '0;
            vcnt_reg   <= '0;
        end
        if (state_reg == ST_MAP) begin
            case (quad_t'(phase_reg[31:30]))
                QUAD_0: begin
                    cs_reg <= clamp_unit(cx);
                    sn_reg <= clamp_unit(cy);
                end
                QUAD_1: begin
                    cs_reg <= clamp_unit(-cy);
                    sn_reg <= clamp_unit(cx);
                end
                QUAD_2: begin
                    cs_reg <= clamp_unit(-cx);
                    sn_reg <= clamp_unit(-cy);
                end
                default: begin
                    cs_reg <= clamp_unit(cy);
                    sn_reg <= clamp_unit(-cx);
                end
            endcase
        end
        if (state_reg == ST_MUL_Y) begin
            x_res_reg <= round_q30(prod);
        end
        if (emit_load) begin
            phase_reg <= phase_reg + quot[PHASE_W-1:0] + PHASE_W'(rwrap);
            racc_reg  <= rwrap ? SIDES_W'(rsum - {1'b0, n_reg}) : rsum[SIDES_W-1:0];
            vcnt_reg  <= vcnt_reg + VNUM_W'(1);
        end
    end

    // Output register: a finished vertex waits here while the next is computed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (emit_load) begin
            vnum_out_reg <= vcnt_reg;
            x_out_reg    <= x_res_reg;
            y_out_reg    <= round_q30(prod);
            z_out_reg    <= height_reg;
            u_out_reg    <= tex_of(cs_reg);
            v_out_reg    <= tex_of(sn_reg);
            r_out_reg    <= red_reg;
            g_out_reg    <= green_reg;
            b_out_reg    <= blue_reg;
            a_out_reg    <= alpha_reg;
            last_out_reg <= is_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_vertex_number = vnum_out_reg;
    assign m_x_coord       = $signed(x_out_reg);
    assign m_y_coord       = $signed(y_out_reg);
    assign m_z_coord       = z_out_reg;
    assign m_tex_u         = u_out_reg;
    assign m_tex_v         = v_out_reg;
    assign m_out_red       = r_out_reg;
    assign m_out_green     = g_out_reg;
    assign m_out_blue      = b_out_reg;
    assign m_out_alpha     = a_out_reg;
    assign m_last_vertex   = last_out_reg;

    // The divider and the CORDIC only finish while the sequencer waits for them.
    `RPVG_ASSERT(a_div_done_in_div, aclk, aresetn, div_done |-> (state_reg == ST_DIV), "divider finished outside its wait state")
    `RPVG_ASSERT(a_cordic_done_in_wait, aclk, aresetn, cordic_done |-> (state_reg == ST_CORDIC), "CORDIC finished outside its wait state")
    // While vertices are produced the counter and remainder stay below the side count.
    `RPVG_ASSERT(a_vertex_in_range, aclk, aresetn, ((state_reg == ST_PREP) || (state_reg == ST_EMIT)) |-> (({1'b0, vcnt_reg} < n_reg) && (racc_reg < n_reg)), "vertex counter or phase remainder out of range")
    // A pending vertex is never overwritten before its transfer.
    `RPVG_ASSERT(a_no_overwrite, aclk, aresetn, (m_valid_reg && !m_ready && (state_reg == ST_EMIT)) |=> $stable(vnum_out_reg), "pending vertex overwritten")

endmodule

### hdl/rpvg_div.sv
module rpvg_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [rpvg_pkg::SIDES_W-1:0]   divisor,
    output logic [rpvg_pkg::QUOT_W-1:0]    quotient,
    output logic [rpvg_pkg::SIDES_W-1:0]   remainder,
    output logic                           done
);
    import rpvg_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [SIDES_W-1:0]  rem_reg, rem_next;
    logic [SIDES_W-1:0]  div_reg, div_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [SIDES_W:0]    trial;
    logic                fits;

    // One restoring step per cycle on the dividend 2^32, most significant bit first.
    assign trial = {rem_reg, (cnt_reg == 6'd0)};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = '0;
            div_next  = divisor;
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = fits ? SIDES_W'(trial - {1'b0, div_reg}) : trial[SIDES_W-1:0];
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            cnt_next  = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
    end

    assign quotient  = quot_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

### hdl/rpvg_cordic.sv
module rpvg_cordic #(
    parameter int STEPS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [rpvg_pkg::CW-1:0]   z_init,
    output logic signed [rpvg_pkg::CW-1:0]   x_out,
    output logic signed [rpvg_pkg::CW-1:0]   y_out,
    output logic                             done
);
    import rpvg_pkg::*;

    localparam int IW = $clog2(STEPS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [IW-1:0]        cnt_reg, cnt_next;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [CW-1:0] z_reg, z_next;
    logic signed [CW-1:0] dx, dy, da;

    // Shared rotation step: shifted cross terms and the arctangent for this step.
    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign da = $signed({2'b00, ATAN_Q30[5'(cnt_reg)]});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = CORDIC_GAIN_INV;
            y_next    = '0;
            z_next    = z_init;
        end else if (busy_reg) begin
            if (!z_reg[CW-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - da;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + da;
            end
            cnt_next = cnt_reg + IW'(1);
            if (cnt_reg == IW'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign done  = done_reg;

endmodule

### hdl/rpvg_mul.sv
module rpvg_mul (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic [rpvg_pkg::Q88_W-1:0]           radius,
    input  logic signed [rpvg_pkg::TRIG_W-1:0]   trig,
    output logic signed [rpvg_pkg::PROD_W-1:0]   prod
);
    import rpvg_pkg::*;

    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // Radius times cosine or sine, registered; the sequencer picks the operand.
    assign prod_next = PROD_W'($signed({1'b0, radius}) * trig);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
